### sv/tctw_pkg.sv
// Shared types and constants for the text cell terminal writer.
package tctw_pkg;

  localparam int COLS_DEF        = 80;
  localparam int ROWS_DEF        = 25;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int CHAR_W  = 8;
  localparam int CELL_W  = 7;
  localparam int RROW_W  = 5;
  localparam int RCOL_W  = 7;
  localparam int OCOL_W  = 7;
  localparam int OROW_W  = 5;
  localparam int WIDTH_W = 12;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 12'd600;

  localparam int AVG_CHAR_PX    = 10;
  localparam int WRAP_MARGIN_PX = 40;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_DEL   = 8'd127;

  localparam logic [CELL_W-1:0] BLANK_CELL = 7'd32;
  localparam logic [CELL_W-1:0] ZERO_CELL  = 7'd0;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [2:0] {
    K_READ,
    K_NEWLINE,
    K_RETURN,
    K_BACKSPACE,
    K_PRINT,
    K_IGNORE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CELL_W-1:0] chr;
    logic [RROW_W-1:0] rrow;
    logic [RCOL_W-1:0] rcol;
  } cmd_t;

endpackage

### sv/tctw_ram.sv
// Generic single-port RAM with registered read data.
module tctw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/tctw_front.sv
// Front end: accepts words and sorts each byte into a command for the back end.
module tctw_front import tctw_pkg::*; (
  input  logic              start,
  input  logic              in_op,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [RROW_W-1:0] in_read_row,
  input  logic [RCOL_W-1:0] in_read_col,
  input  logic              q_full,
  input  logic              clearing,
  output logic              busy,
  output logic              push,
  output cmd_t              push_cmd
);

  assign busy = q_full | clearing;
  assign push = start & ~busy;

  always_comb begin
    push_cmd.chr  = in_char_code[CELL_W-1:0];
    push_cmd.rrow = in_read_row;
    push_cmd.rcol = in_read_col;
    priority if (in_op == OP_READ) begin
      push_cmd.kind = K_READ;
    end else if (in_char_code == CH_LF) begin
      push_cmd.kind = K_NEWLINE;
    end else if (in_char_code == CH_CR) begin
      push_cmd.kind = K_RETURN;
    end else if (in_char_code == CH_BS) begin
      push_cmd.kind = K_BACKSPACE;
    end else if (in_char_code >= CH_SPACE && in_char_code < CH_DEL) begin
      push_cmd.kind = K_PRINT;
    end else begin
      push_cmd.kind = K_IGNORE;
    end
  end

endmodule

### sv/tctw_queue.sv
// Short command queue between the front end and the back end.
module tctw_queue import tctw_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  cmd_t             slot_r [DEPTH];
  logic [IDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(DEPTH));
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### sv/tctw_back.sv
// Back end: cursor logic, cell store access, scrolling and the result register.
module tctw_back import tctw_pkg::*; #(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [WIDTH_W-1:0] cfg_width,
  input  logic               q_empty,
  input  cmd_t               q_head,
  output logic               q_pop,
  output logic               clearing,
  output logic               out_valid,
  output logic [OCOL_W-1:0]  out_cursor_col,
  output logic [OROW_W-1:0]  out_cursor_row,
  output logic [CELL_W-1:0]  out_cell_char,
  output logic               out_did_scroll
);

  localparam int COL_W  = $clog2(COLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COLX_W = COL_W + 1;
  localparam int ROWX_W = ROW_W + 1;
  localparam int DEPTH  = ROWS * COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CMP_W  = ((COL_W + 6) > WIDTH_W) ? (COL_W + 6) : WIDTH_W;

  localparam logic [ROWX_W-1:0] ROWS_X    = ROWX_W'(ROWS);
  localparam logic [COLX_W-1:0] COLS_X    = COLX_W'(COLS);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLS - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_EXEC   = 6'b000100,
    ST_ACCESS = 6'b001000,
    ST_RDWAIT = 6'b010000,
    ST_SCROLL = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic               wrap_r, wrap_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [ROW_W-1:0]   top_r, top_nxt;
  logic [ROW_W-1:0]   prow_r, prow_nxt;
  logic [COL_W-1:0]   acol_r, acol_nxt;
  logic               acc_r, acc_nxt;
  logic               scroll_r, scroll_nxt;
  logic [CELL_W-1:0]  wdata_r, wdata_nxt;
  logic [ADDR_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [COL_W-1:0]   fill_col_r, fill_col_nxt;
  logic [ROW_W-1:0]   fill_row_r, fill_row_nxt;
  logic [ADDR_W-1:0]  fill_base_r, fill_base_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [OCOL_W-1:0]  ocol_r, ocol_nxt;
  logic [OROW_W-1:0]  orow_r, orow_nxt;
  logic [CELL_W-1:0]  ocell_r, ocell_nxt;
  logic               oscroll_r, oscroll_nxt;

  // Execute-step values.
  logic [ROWX_W-1:0]  ex_row, ex_new_row, pr_row, psum;
  logic [COLX_W-1:0]  ex_new_col, pr_col1;
  logic [COL_W-1:0]   pr_col, ex_acol;
  logic [ROW_W-1:0]   ex_arow, ex_prow;
  logic               ex_acc, ex_scroll;
  logic [CELL_W-1:0]  ex_wdata;

  logic [CMP_W-1:0]   wrap_px;
  logic               wrap_now;
  logic [ADDR_W-1:0]  acc_addr;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_addr;
  logic [CELL_W-1:0]  ram_wdata, ram_rdata;

  tctw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Early wrap when col*10 + 40 exceeds the window width.
  assign wrap_px  = CMP_W'(col_r) * CMP_W'(AVG_CHAR_PX) + CMP_W'(WRAP_MARGIN_PX);
  assign wrap_now = (wrap_px > CMP_W'(cfg_width));

  assign acc_addr = ADDR_W'(ADDR_W'(prow_r) * ADDR_W'(COLS)) + ADDR_W'(acol_r);

  assign clearing = (state_r == ST_CLEAR);

  always_comb begin
    ex_row     = {1'b0, row_r};
    ex_new_row = ex_row;
    ex_new_col = {1'b0, col_r};
    ex_acc     = 1'b0;
    ex_arow    = row_r;
    ex_acol    = col_r;
    ex_wdata   = BLANK_CELL;
    pr_row     = wrap_r ? ex_row + 1'b1 : ex_row;
    pr_col     = wrap_r ? '0 : col_r;
    pr_col1    = {1'b0, pr_col} + 1'b1;
    unique case (cmd_r.kind)
      K_READ: begin
        if (int'(cmd_r.rrow) < ROWS && int'(cmd_r.rcol) < COLS) begin
          ex_acc  = 1'b1;
          ex_arow = ROW_W'(cmd_r.rrow);
          ex_acol = COL_W'(cmd_r.rcol);
        end
      end
      K_NEWLINE: begin
        ex_new_col = '0;
        ex_new_row = ex_row + 1'b1;
      end
      K_RETURN: begin
        ex_new_col = '0;
      end
      K_BACKSPACE: begin
        if (col_r != '0) begin
          ex_new_col = {1'b0, col_r} - 1'b1;
          ex_acc     = 1'b1;
          ex_acol    = col_r - 1'b1;
        end
      end
      K_PRINT: begin
        if (pr_row < ROWS_X) begin
          ex_acc   = 1'b1;
          ex_arow  = pr_row[ROW_W-1:0];
          ex_acol  = pr_col;
          ex_wdata = cmd_r.chr;
          if (pr_col1 == COLS_X) begin
            ex_new_col = '0;
            ex_new_row = pr_row + 1'b1;
          end else begin
            ex_new_col = pr_col1;
            ex_new_row = pr_row;
          end
        end else begin
          // The wrap ran off the bottom: the character is dropped.
          ex_new_col = '0;
          ex_new_row = pr_row;
        end
      end
      default: begin
      end
    endcase
    ex_scroll = (ex_new_row == ROWS_X);
    // Rows are kept in a ring; top_r is the physical row shown as row zero.
    psum      = {1'b0, ex_arow} + {1'b0, top_r};
    ex_prow   = (psum >= ROWS_X) ? ROW_W'(psum - ROWS_X) : psum[ROW_W-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    wrap_nxt      = wrap_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    top_nxt       = top_r;
    prow_nxt      = prow_r;
    acol_nxt      = acol_r;
    acc_nxt       = acc_r;
    scroll_nxt    = scroll_r;
    wdata_nxt     = wdata_r;
    clr_addr_nxt  = clr_addr_r;
    fill_col_nxt  = fill_col_r;
    fill_row_nxt  = fill_row_r;
    fill_base_nxt = fill_base_r;
    ovalid_nxt    = 1'b0;
    ocol_nxt      = ocol_r;
    orow_nxt      = orow_r;
    ocell_nxt     = ocell_r;
    oscroll_nxt   = oscroll_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_addr      = '0;
    ram_wdata     = wdata_r;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr_r;
        ram_wdata = ZERO_CELL;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_head;
          wrap_nxt  = wrap_now;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        col_nxt    = ex_new_col[COL_W-1:0];
        row_nxt    = ex_scroll ? LAST_ROW : ex_new_row[ROW_W-1:0];
        acc_nxt    = ex_acc;
        prow_nxt   = ex_prow;
        acol_nxt   = ex_acol;
        wdata_nxt  = ex_wdata;
        scroll_nxt = ex_scroll;
        if (ex_scroll) begin
          top_nxt      = (top_r == LAST_ROW) ? '0 : top_r + 1'b1;
          fill_row_nxt = top_r;
        end
        state_nxt = ST_ACCESS;
      end
      ST_ACCESS: begin
        ram_addr = acc_addr;
        if (cmd_r.kind == K_READ) begin
          ram_re = acc_r;
          if (acc_r) begin
            state_nxt = ST_RDWAIT;
          end else begin
            ovalid_nxt  = 1'b1;
            ocol_nxt    = OCOL_W'(col_r);
            orow_nxt    = OROW_W'(row_r);
            ocell_nxt   = ZERO_CELL;
            oscroll_nxt = 1'b0;
            state_nxt   = ST_IDLE;
          end
        end else begin
          ram_we = acc_r;
          if (scroll_r) begin
            fill_base_nxt = ADDR_W'(ADDR_W'(fill_row_r) * ADDR_W'(COLS));
            fill_col_nxt  = '0;
            state_nxt     = ST_SCROLL;
          end else begin
            ovalid_nxt  = 1'b1;
            ocol_nxt    = OCOL_W'(col_r);
            orow_nxt    = OROW_W'(row_r);
            ocell_nxt   = ZERO_CELL;
            oscroll_nxt = 1'b0;
            state_nxt   = ST_IDLE;
          end
        end
      end
      ST_RDWAIT: begin
        ovalid_nxt  = 1'b1;
        ocol_nxt    = OCOL_W'(col_r);
        orow_nxt    = OROW_W'(row_r);
        ocell_nxt   = ram_rdata;
        oscroll_nxt = 1'b0;
        state_nxt   = ST_IDLE;
      end
      ST_SCROLL: begin
        // The old top row becomes the new bottom row and is filled with spaces.
        ram_we    = 1'b1;
        ram_addr  = fill_base_r + ADDR_W'(fill_col_r);
        ram_wdata = BLANK_CELL;
        if (fill_col_r == LAST_COL) begin
          ovalid_nxt  = 1'b1;
          ocol_nxt    = OCOL_W'(col_r);
          orow_nxt    = OROW_W'(row_r);
          ocell_nxt   = ZERO_CELL;
          oscroll_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          fill_col_nxt = fill_col_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      col_r      <= '0;
      row_r      <= '0;
      top_r      <= '0;
      ovalid_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      top_r      <= top_nxt;
      ovalid_r   <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    wrap_r      <= wrap_nxt;
    prow_r      <= prow_nxt;
    acol_r      <= acol_nxt;
    acc_r       <= acc_nxt;
    scroll_r    <= scroll_nxt;
    wdata_r     <= wdata_nxt;
    fill_col_r  <= fill_col_nxt;
    fill_row_r  <= fill_row_nxt;
    fill_base_r <= fill_base_nxt;
    ocol_r      <= ocol_nxt;
    orow_r      <= orow_nxt;
    ocell_r     <= ocell_nxt;
    oscroll_r   <= oscroll_nxt;
  end

  assign out_valid      = ovalid_r;
  assign out_cursor_col = ocol_r;
  assign out_cursor_row = orow_r;
  assign out_cell_char  = ocell_r;
  assign out_did_scroll = oscroll_r;

endmodule

### sv/text_cell_terminal_writer_core.sv
// Top level of the text cell terminal writer: config register, front end, queue, back end.
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   ------------------------------
//   input     in_op in_char_code in_read_row          word taken when start && !busy
//             in_read_col
//   result    out_cursor_col out_cursor_row           one word per input word, shown
//             out_cell_char out_did_scroll            for one cycle with out_valid
//   config    cfg_wr_en cfg_wr_data                   written when cfg_wr_en is high
//
// After reset the cell store is cleared to zero, one cell per cycle, and busy
// stays high until the clear is done.
// A write word passes the back end's idle, execute and access states and an in-range read
// word a read-wait state as well, the cell store's single port and its registered
// read setting that extra state. A write that scrolls then fills the new bottom
// row with spaces through that same port; rows live in a ring, so no other row
// is moved.
// The command queue lets the front end take new words while the back end is
// still working; busy rises only when the queue is full or the store is being
// cleared. The receiver cannot stall: each result word stands for one cycle.
module text_cell_terminal_writer_core import tctw_pkg::*; #(
  parameter int COLS        = COLS_DEF,
  parameter int ROWS        = ROWS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic [CHAR_W-1:0]  in_char_code,
  input  logic [RROW_W-1:0]  in_read_row,
  input  logic [RCOL_W-1:0]  in_read_col,
  input  logic               cfg_wr_en,
  input  logic [WIDTH_W-1:0] cfg_wr_data,
  output logic               out_valid,
  output logic [OCOL_W-1:0]  out_cursor_col,
  output logic [OROW_W-1:0]  out_cursor_row,
  output logic [CELL_W-1:0]  out_cell_char,
  output logic               out_did_scroll
);

  // Window width in pixels; it sets the column at which lines wrap early.
  logic [WIDTH_W-1:0] width_r, width_nxt;

  logic q_push, q_pop, q_empty, q_full, clearing;
  cmd_t push_cmd, q_head;

  assign width_nxt = cfg_wr_en ? cfg_wr_data : width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RESET;
    end else begin
      width_r <= width_nxt;
    end
  end

  // The front end turns each accepted word into a classified command.
  tctw_front u_front (
    .start        (start),
    .in_op        (in_op),
    .in_char_code (in_char_code),
    .in_read_row  (in_read_row),
    .in_read_col  (in_read_col),
    .q_full       (q_full),
    .clearing     (clearing),
    .busy         (busy),
    .push         (q_push),
    .push_cmd     (push_cmd)
  );

  // Commands wait here until the back end is free.
  tctw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // The back end owns the cursor and the cell store and drives the results.
  tctw_back #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_width      (width_r),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_cell_char  (out_cell_char),
    .out_did_scroll (out_did_scroll)
  );

endmodule

### tb/text_cell_terminal_writer_core_test.sv
// Self-checking testbench for the text cell terminal writer core.
module text_cell_terminal_writer_core_test;
  import tctw_pkg::*;

  // One result word as the block shows it on its out_ ports.
  typedef struct packed {
    logic [OCOL_W-1:0] col;
    logic [OROW_W-1:0] row;
    logic [CELL_W-1:0] cell_ch;
    logic              scroll;
  } console_word_t;

  // A row of the directed table either sends a word (possibly several times)
  // or sets a new window width once the block has gone quiet.
  typedef enum logic {ROW_WORD, ROW_WIDTH} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic               op;
    logic [CHAR_W-1:0]  ch;
    logic [RROW_W-1:0]  rr;
    logic [RCOL_W-1:0]  rc;
    logic [5:0]         reps;
    logic               pinned;
    logic [WIDTH_W-1:0] width;
    console_word_t      want;
  } stim_row_t;

  localparam console_word_t HOME = '{7'd0, 5'd0, 7'd0, 1'b0};

  // Directed opening. Rows with pinned set carry a result that is obvious from
  // the cleared screen; the rest are checked against the console predictor.
  localparam stim_row_t STIM_TAB [17] = '{
    // Fresh screen: a corner cell and a fully out-of-range cell read as zero.
    '{ROW_WORD,  OP_READ,  8'd0,   5'd0,  7'd0,   6'd1,  1'b1, 12'd0,   HOME},
    '{ROW_WORD,  OP_READ,  8'd0,   5'd31, 7'd127, 6'd1,  1'b1, 12'd0,   HOME},
    // A letter and the highest printable byte, then a backspace that blanks the '~'.
    '{ROW_WORD,  OP_WRITE, 8'h41,  5'd0,  7'd0,   6'd1,  1'b1, 12'd0,
      '{7'd1, 5'd0, 7'd0, 1'b0}},
    '{ROW_WORD,  OP_WRITE, 8'h7e,  5'd0,  7'd0,   6'd1,  1'b1, 12'd0,
      '{7'd2, 5'd0, 7'd0, 1'b0}},
    '{ROW_WORD,  OP_WRITE, CH_BS,  5'd0,  7'd0,   6'd1,  1'b1, 12'd0,
      '{7'd1, 5'd0, 7'd0, 1'b0}},
    '{ROW_WORD,  OP_READ,  8'd0,   5'd0,  7'd1,   6'd1,  1'b1, 12'd0,
      '{7'd1, 5'd0, 7'd32, 1'b0}},
    // Carriage return, then a backspace at column zero that must do nothing.
    '{ROW_WORD,  OP_WRITE, CH_CR,  5'd0,  7'd0,   6'd1,  1'b1, 12'd0,   HOME},
    '{ROW_WORD,  OP_WRITE, CH_BS,  5'd0,  7'd0,   6'd1,  1'b1, 12'd0,   HOME},
    // Bytes the writer ignores: a control code, delete and the top byte.
    '{ROW_WORD,  OP_WRITE, 8'd0,   5'd0,  7'd0,   6'd1,  1'b1, 12'd0,   HOME},
    '{ROW_WORD,  OP_WRITE, CH_DEL, 5'd0,  7'd0,   6'd1,  1'b1, 12'd0,   HOME},
    '{ROW_WORD,  OP_WRITE, 8'd255, 5'd0,  7'd0,   6'd1,  1'b1, 12'd0,   HOME},
    // Zero width: every printable byte wraps first, so 24 of them walk the
    // cursor down the screen and the last one falls off the bottom and scrolls.
    '{ROW_WIDTH, OP_WRITE, 8'd0,   5'd0,  7'd0,   6'd0,  1'b0, 12'd0,   HOME},
    '{ROW_WORD,  OP_WRITE, 8'h7a,  5'd0,  7'd0,   6'd25, 1'b0, 12'd0,   HOME},
    '{ROW_WIDTH, OP_WRITE, 8'd0,   5'd0,  7'd0,   6'd0,  1'b0, 12'd600, HOME},
    // Newline on the bottom row scrolls too; the new bottom row reads as spaces.
    '{ROW_WORD,  OP_WRITE, CH_LF,  5'd0,  7'd0,   6'd1,  1'b0, 12'd0,   HOME},
    '{ROW_WORD,  OP_READ,  8'd0,   5'd24, 7'd0,   6'd1,  1'b0, 12'd0,   HOME},
    '{ROW_WORD,  OP_READ,  8'd0,   5'd0,  7'd80,  6'd1,  1'b0, 12'd0,   HOME}
  };

  // Window widths of the random phases. Phase 0 keeps the width the directed
  // part left, phase 5 draws one at random. 39 and 40 sit on either side of
  // the point where the early wrap limit turns negative; 829 is the widest
  // setting that still wraps early, and only at the last column.
  localparam int PHASE_WIDTHS [7] = '{600, 4095, 39, 40, 829, 0, 1};
  localparam int PHASE_WORDS = 225;
  localparam int CALM_PHASE  = 4;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_op;
  logic [CHAR_W-1:0]  in_char_code;
  logic [RROW_W-1:0]  in_read_row;
  logic [RCOL_W-1:0]  in_read_col;
  logic               cfg_wr_en;
  logic [WIDTH_W-1:0] cfg_wr_data;
  logic               out_valid;
  logic [OCOL_W-1:0]  out_cursor_col;
  logic [OROW_W-1:0]  out_cursor_row;
  logic [CELL_W-1:0]  out_cell_char;
  logic               out_did_scroll;

  // Console predictor state: its own copy of the screen, cursor and width.
  logic [CELL_W-1:0]  screen_model [ROWS_DEF*COLS_DEF];
  int                 cursor_x;
  int                 cursor_y;
  logic [WIDTH_W-1:0] width_model;

  // Results still owed by the block, oldest first.
  console_word_t predicted_words [$];

  int errors;
  int words_sent;
  int reads_sent;
  int scrolls_predicted;
  int results_seen;
  int width_writes;

  text_cell_terminal_writer_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_char_code   (in_char_code),
    .in_read_row    (in_read_row),
    .in_read_col    (in_read_col),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_valid      (out_valid),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_cell_char  (out_cell_char),
    .out_did_scroll (out_did_scroll)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Generous cap: even if every word scrolled and every gap were the longest
  // one, the run would finish well inside this.
  initial begin
    #2000000;
    $display("text_cell_terminal_writer_core_test: errors");
    $finish;
  end

  // Prints the first batch of mismatches and counts all of them.
  task automatic report_mismatch(input string msg);
    if (errors < 50) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
    errors++;
  endtask

  // Applies one accepted word to the console predictor and returns the result
  // word the block should produce for it.
  function automatic console_word_t advance_console(input logic op,
      input logic [CHAR_W-1:0] ch, input logic [RROW_W-1:0] rr,
      input logic [RCOL_W-1:0] rc);
    console_word_t w;
    int            limit;
    int            i;
    w = '0;
    if (op == OP_WRITE) begin
      if (ch == CH_LF) begin
        cursor_x = 0;
        cursor_y++;
      end else if (ch == CH_CR) begin
        cursor_x = 0;
      end else if (ch == CH_BS) begin
        if (cursor_x > 0) begin
          cursor_x--;
          screen_model[cursor_y*COLS_DEF + cursor_x] = BLANK_CELL;
        end
      end else if (ch >= CH_SPACE && ch < CH_DEL) begin
        // The early wrap limit is signed: a narrow window makes it negative.
        limit = int'(width_model) - WRAP_MARGIN_PX;
        if (cursor_x*AVG_CHAR_PX > limit) begin
          cursor_x = 0;
          cursor_y++;
        end
        // A byte that wrapped off the bottom row is dropped.
        if (cursor_y < ROWS_DEF) begin
          screen_model[cursor_y*COLS_DEF + cursor_x] = ch[CELL_W-1:0];
          cursor_x++;
          if (cursor_x >= COLS_DEF) begin
            cursor_x = 0;
            cursor_y++;
          end
        end
      end
      // Any write, even an ignored byte, settles a pending scroll.
      if (cursor_y >= ROWS_DEF) begin
        for (i = 0; i < (ROWS_DEF-1)*COLS_DEF; i++) begin
          screen_model[i] = screen_model[i + COLS_DEF];
        end
        for (i = (ROWS_DEF-1)*COLS_DEF; i < ROWS_DEF*COLS_DEF; i++) begin
          screen_model[i] = BLANK_CELL;
        end
        cursor_y = ROWS_DEF - 1;
        w.scroll = 1'b1;
      end
    end else if (rr < ROWS_DEF && rc < COLS_DEF) begin
      w.cell_ch = screen_model[rr*COLS_DEF + rc];
    end
    w.col = cursor_x[OCOL_W-1:0];
    w.row = cursor_y[OROW_W-1:0];
    return w;
  endfunction

  // Presents one word and holds it until the block takes it. Returns at the
  // clock edge of the handshake, where the word enters the predictor.
  task automatic send_word(input logic op, input logic [CHAR_W-1:0] ch,
      input logic [RROW_W-1:0] rr, input logic [RCOL_W-1:0] rc,
      input logic pinned, input console_word_t want);
    console_word_t w;
    start        <= 1'b1;
    in_op        <= op;
    in_char_code <= ch;
    in_read_row  <= rr;
    in_read_col  <= rc;
    do @(posedge clk); while (busy);
    w = advance_console(op, ch, rr, rc);
    if (pinned) begin
      w = want;
    end
    predicted_words.push_back(w);
    words_sent++;
    if (op == OP_READ) begin
      reads_sent++;
    end
    if (w.scroll) begin
      scrolls_predicted++;
    end
  endtask

  task automatic idle_gap(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stops sending and waits until every owed result word has come back.
  task automatic drain_results();
    start <= 1'b0;
    while (predicted_words.size() != 0) @(posedge clk);
  endtask

  // The width register is only touched once the block has gone quiet.
  task automatic write_width(input logic [WIDTH_W-1:0] value);
    drain_results();
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    width_model = value;
    width_writes++;
  endtask

  // Result checker. A result word stands for exactly one cycle, so it is
  // sampled at the edge that ends that cycle and matched to the oldest
  // prediction, one field at a time.
  always @(posedge clk) begin
    console_word_t w;
    if (rst_n && out_valid) begin
      results_seen++;
      if (predicted_words.size() == 0) begin
        report_mismatch($sformatf("result word %0d arrived with none owed", results_seen));
      end else begin
        w = predicted_words.pop_front();
        if (out_cursor_col !== w.col) begin
          report_mismatch($sformatf("word %0d cursor_col got %0d want %0d",
                                    results_seen, out_cursor_col, w.col));
        end
        if (out_cursor_row !== w.row) begin
          report_mismatch($sformatf("word %0d cursor_row got %0d want %0d",
                                    results_seen, out_cursor_row, w.row));
        end
        if (out_cell_char !== w.cell_ch) begin
          report_mismatch($sformatf("word %0d cell_char got %0d want %0d",
                                    results_seen, out_cell_char, w.cell_ch));
        end
        if (out_did_scroll !== w.scroll) begin
          report_mismatch($sformatf("word %0d did_scroll got %0b want %0b",
                                    results_seen, out_did_scroll, w.scroll));
        end
      end
    end
  end

  initial begin
    int                ph;
    int                useful;
    int                pick;
    logic              op;
    logic [CHAR_W-1:0] ch;
    logic [RROW_W-1:0] rr;
    logic [RCOL_W-1:0] rc;

    // Every input is known from time zero; reset is held low first, then released.
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_op        <= OP_WRITE;
    in_char_code <= '0;
    in_read_row  <= '0;
    in_read_col  <= '0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    errors            = 0;
    words_sent        = 0;
    reads_sent        = 0;
    scrolls_predicted = 0;
    results_seen      = 0;
    width_writes      = 0;
    for (int i = 0; i < ROWS_DEF*COLS_DEF; i++) begin
      screen_model[i] = ZERO_CELL;
    end
    cursor_x    = 0;
    cursor_y    = 0;
    width_model = WIDTH_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // The block clears its screen after reset and keeps busy high meanwhile;
    // the first word simply waits at the handshake until that is done.
    foreach (STIM_TAB[k]) begin
      if (STIM_TAB[k].kind == ROW_WIDTH) begin
        write_width(STIM_TAB[k].width);
      end else begin
        repeat (STIM_TAB[k].reps) begin
          send_word(STIM_TAB[k].op, STIM_TAB[k].ch, STIM_TAB[k].rr, STIM_TAB[k].rc,
                    STIM_TAB[k].pinned, STIM_TAB[k].want);
        end
      end
    end

    // Random phases, each at its own window width. Most words are printable
    // text with some line control mixed in, so the cursor keeps reaching the
    // bottom and the screen scrolls often. Reads mostly hit the visible
    // screen, with a share of out-of-range addresses. Ignored bytes are sent
    // too but do not count toward the phase's word budget.
    for (ph = 0; ph < 7; ph++) begin
      if (ph == 5) begin
        write_width(WIDTH_W'($urandom_range(4095)));
      end else if (ph > 0) begin
        write_width(WIDTH_W'(PHASE_WIDTHS[ph]));
      end
      useful = 0;
      while (useful < PHASE_WORDS) begin
        // The calm phase sends back to back; elsewhere gaps are mostly short,
        // with some long enough to land in the middle of a scroll's row fill.
        if (ph != CALM_PHASE && $urandom_range(99) < 18) begin
          if ($urandom_range(9) == 0) begin
            idle_gap($urandom_range(5, 90));
          end else begin
            idle_gap($urandom_range(1, 4));
          end
        end else if ($urandom_range(199) == 0) begin
          drain_results();
        end
        rr = '0;
        rc = '0;
        ch = '0;
        if ($urandom_range(99) < 25) begin
          op = OP_READ;
          rr = ($urandom_range(7) == 0) ? RROW_W'($urandom_range(31))
                                        : RROW_W'($urandom_range(ROWS_DEF-1));
          rc = ($urandom_range(7) == 0) ? RCOL_W'($urandom_range(127))
                                        : RCOL_W'($urandom_range(COLS_DEF-1));
          ch = CHAR_W'($urandom_range(255));
        end else begin
          op   = OP_WRITE;
          rr   = RROW_W'($urandom_range(31));
          rc   = RCOL_W'($urandom_range(127));
          pick = $urandom_range(99);
          if (pick < 62) begin
            ch = CHAR_W'($urandom_range(32, 126));
          end else if (pick < 72) begin
            ch = CH_LF;
          end else if (pick < 77) begin
            ch = CH_CR;
          end else if (pick < 87) begin
            ch = CH_BS;
          end else if (pick < 92) begin
            ch = CHAR_W'($urandom_range(31));
          end else if (pick < 94) begin
            ch = CH_DEL;
          end else begin
            ch = CHAR_W'($urandom_range(128, 255));
          end
        end
        send_word(op, ch, rr, rc, 1'b0, HOME);
        if (op == OP_READ || ch == CH_BS || ch == CH_LF || ch == CH_CR ||
            (ch >= CH_SPACE && ch < CH_DEL)) begin
          useful++;
        end
      end
    end

    // Let the last scroll fill and the last result word come out, then allow
    // a margin in which any stray result word would still be caught.
    drain_results();
    repeat (120) @(posedge clk);

    $display("Sent %0d words (%0d reads) across %0d width settings;",
             words_sent, reads_sent, width_writes);
    $display("checked %0d result words, %0d of them scrolls.",
             results_seen, scrolls_predicted);
    if (errors == 0 && predicted_words.size() == 0) begin
      $display("text_cell_terminal_writer_core_test: clean");
    end else begin
      $display("text_cell_terminal_writer_core_test: errors");
    end
    $finish;
  end

endmodule
